>>> src/lsmm_pkg.sv
// shared types and constants for the line sensor min/max threshold block
// no dependencies
`default_nettype none

package lsmm_pkg;

    localparam int DEF_NUM_CHANNELS = 8;
    localparam int DEF_ADC_BITS     = 12;

    localparam int CHANNEL_W   = 3;
    localparam int SAMPLE_W    = 12;
    localparam int MASK_W      = 8;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 16;

    typedef enum logic [0:0] {
        CMD_SAMPLE = 1'b0,
        CMD_TOGGLE = 1'b1
    } t_cmd;

    typedef enum logic [0:0] {
        MODE_RUN = 1'b0,
        MODE_CAL = 1'b1
    } t_mode;

    typedef struct packed {
        t_cmd                 cmd;
        logic [CHANNEL_W-1:0] channel;
        logic [SAMPLE_W-1:0]  sample;
        logic                 frame_end;
    } t_item;

    typedef struct packed {
        logic cal_upd;
        logic clr_ext;
    } t_store_ctl;

endpackage

`default_nettype wire

>>> src/lsmm_in_stage.sv
// input register stage holding one accepted transaction
// depends on lsmm_pkg
`default_nettype none

module lsmm_in_stage
    import lsmm_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    input  t_item i_item,
    input  wire   i_take,
    output logic  o_ready,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_in_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

>>> src/lsmm_chan_store.sv
// per-channel threshold, maximum and minimum registers with calibration update
// depends on lsmm_pkg
`default_nettype none

module lsmm_chan_store
    import lsmm_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    parameter int ADC_BITS     = DEF_ADC_BITS,
    localparam int CH_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  t_store_ctl          i_ctl,
    input  wire  [CH_W-1:0]     i_idx,
    input  wire  [ADC_BITS-1:0] i_sample,
    output logic [ADC_BITS-1:0] o_thr
);

    localparam logic [ADC_BITS-1:0] MID_SCALE  = ADC_BITS'(1) << (ADC_BITS - 1);
    localparam logic [ADC_BITS-1:0] FULL_SCALE = '1;

    logic [ADC_BITS-1:0] r_thr [NUM_CHANNELS];
    logic [ADC_BITS-1:0] r_max [NUM_CHANNELS];
    logic [ADC_BITS-1:0] r_min [NUM_CHANNELS];

    logic [ADC_BITS-1:0] n_max;
    logic [ADC_BITS-1:0] n_min;
    logic [ADC_BITS:0]   n_sum;

    assign o_thr = r_thr[i_idx];

    always_comb begin
        n_max = (r_max[i_idx] < i_sample) ? i_sample : r_max[i_idx];
        n_min = (r_min[i_idx] > i_sample) ? i_sample : r_min[i_idx];
        n_sum = {1'b0, n_max} + {1'b0, n_min};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_thr[k] <= MID_SCALE;
                r_max[k] <= '0;
                r_min[k] <= FULL_SCALE;
            end
        end else if (i_ctl.clr_ext) begin
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_max[k] <= '0;
                r_min[k] <= FULL_SCALE;
            end
        end else if (i_ctl.cal_upd) begin
            r_max[i_idx] <= n_max;
            r_min[i_idx] <= n_min;
            r_thr[i_idx] <= n_sum[ADC_BITS:1];
        end
    end

endmodule

`default_nettype wire

>>> src/line_sensor_minmax_calibrated_threshold.sv
// line sensor thresholding with min/max midpoint calibration, top level
// input and output are registered; per-channel state is read and written in the same cycle
// throughput: one input transaction per cycle while the output is not stalled
// reset: synchronous active low; thresholds to mid-scale, maxima to zero, minima to full scale,
// mask cleared, run mode, both register stages emptied
// depends on lsmm_pkg, lsmm_in_stage, lsmm_chan_store
`default_nettype none

module line_sensor_minmax_calibrated_threshold
    import lsmm_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    parameter int ADC_BITS     = DEF_ADC_BITS
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire  [S_TDATA_W-1:0] s_axis_tdata,   // channel[2:0], sample[14:3], zero pad
    input  wire                  s_axis_tuser,   // cmd
    input  wire                  s_axis_tlast,   // frame_end
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // line_mask[7:0], mode[8], zero pad
    output logic                 m_axis_tuser    // is_mode_change
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    t_item               w_in_item;
    t_item               w_item;
    logic                w_item_valid;
    logic                w_take;
    t_store_ctl          w_ctl;
    logic [CH_W-1:0]     w_idx;
    logic [ADC_BITS-1:0] w_sample;
    logic [ADC_BITS-1:0] w_thr;
    logic                w_ch_ok;

    t_mode               r_mode;
    t_mode               n_mode;
    logic [MASK_W-1:0]   r_mask;
    logic [MASK_W-1:0]   n_mask;
    logic [MASK_W-1:0]   w_mask_hit;

    logic                r_out_valid;
    logic [MASK_W-1:0]   r_out_mask;
    t_mode               r_out_mode;
    logic                r_out_chg;
    logic                n_res;
    logic [MASK_W-1:0]   n_res_mask;
    t_mode               n_res_mode;
    logic                n_res_chg;

    assign w_in_item.cmd       = t_cmd'(s_axis_tuser);
    assign w_in_item.channel   = s_axis_tdata[CHANNEL_W-1:0];
    assign w_in_item.sample    = s_axis_tdata[CHANNEL_W+SAMPLE_W-1:CHANNEL_W];
    assign w_in_item.frame_end = s_axis_tlast;

    lsmm_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_item     (w_in_item),
        .i_take     (w_take),
        .o_ready    (s_axis_tready),
        .o_valid    (w_item_valid),
        .o_item     (w_item)
    );

    assign w_take   = w_item_valid && (!r_out_valid || m_axis_tready);
    assign w_idx    = CH_W'(w_item.channel);
    assign w_sample = ADC_BITS'(w_item.sample);
    assign w_ch_ok  = (int'(w_item.channel) < NUM_CHANNELS) && (int'(w_item.channel) < MASK_W);

    lsmm_chan_store #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .ADC_BITS     (ADC_BITS)
    ) u_chan_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_idx    (w_idx),
        .i_sample (w_sample),
        .o_thr    (w_thr)
    );

    always_comb begin
        w_mask_hit = '0;
        if (w_ch_ok && (w_sample > w_thr)) begin
            w_mask_hit = MASK_W'(1) << w_item.channel;
        end
        w_ctl      = '0;
        n_mode     = r_mode;
        n_mask     = r_mask;
        n_res      = 1'b0;
        n_res_mask = '0;
        n_res_mode = MODE_RUN;
        n_res_chg  = 1'b0;
        if (w_take) begin
            if (w_item.cmd == CMD_TOGGLE) begin
                n_mask = '0;
                if (r_mode == MODE_RUN) begin
                    w_ctl.clr_ext = 1'b1;
                    n_mode        = MODE_CAL;
                end else begin
                    n_mode    = MODE_RUN;
                    n_res     = 1'b1;
                    n_res_chg = 1'b1;
                end
            end else if (r_mode == MODE_CAL) begin
                w_ctl.cal_upd = w_ch_ok;
            end else if (w_item.frame_end) begin
                n_res      = 1'b1;
                n_res_mask = r_mask | w_mask_hit;
                n_mask     = '0;
            end else begin
                n_mask = r_mask | w_mask_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_RUN;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_mask <= n_mask;
            if (n_res) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_res) begin
            r_out_mask <= n_res_mask;
            r_out_mode <= n_res_mode;
            r_out_chg  <= n_res_chg;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W - MASK_W - 1){1'b0}}, r_out_mode, r_out_mask};
    assign m_axis_tuser  = r_out_chg;

endmodule

`default_nettype wire
